>>> hdl/bbd_pkg.sv
// ---------------------------------------------------------------------------
// bbd_pkg: shared constants and types of the box binning downscaler
// Sizes of the pixel path, line store and configuration port, and the word
// passed from the accumulate stage to the line store update stage.
// ---------------------------------------------------------------------------
`default_nettype none

package bbd_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_SHIFT  = 4;
  localparam int PIXEL_BITS = 16;

  // configuration field widths
  localparam int SHIFT_W    = 3;
  localparam int WIDTH_W    = 13;
  localparam int HEIGHT_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // output field width
  localparam int OUT_W      = 16;

  // derived sizes
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = HEIGHT_W;
  localparam int SH_W   = $clog2(MAX_SHIFT + 1);
  localparam int BRS_W  = PIXEL_BITS + MAX_SHIFT + 1;
  localparam int CSUM_W = PIXEL_BITS + 2 * MAX_SHIFT + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHIFT  = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_SIGNED = 2'd3
  } cfg_reg_t;

  // one closed block row segment on its way to the line store
  typedef struct packed {
    logic signed [BRS_W-1:0] sum;
    logic [COL_W-1:0]        bc;
    logic [SH_W-1:0]         shift;
    logic                    band_first;
    logic                    band_close;
    logic                    row_end;
    logic                    frame_end;
  } bbd_item_t;

endpackage

`default_nettype wire

>>> hdl/bbd_pix_if.sv
// ---------------------------------------------------------------------------
// bbd_pix_if: input pixel channel
// valid/ready handshake carrying one raw pixel word.
// ---------------------------------------------------------------------------
`default_nettype none

interface bbd_pix_if;
  import bbd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

>>> hdl/bbd_out_if.sv
// ---------------------------------------------------------------------------
// bbd_out_if: output average channel
// valid/ready handshake carrying one block average with row/frame markers.
// ---------------------------------------------------------------------------
`default_nettype none

interface bbd_out_if;
  import bbd_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] avg_pixel;
  logic             row_last;
  logic             frame_last;

  modport source (output valid, output avg_pixel, output row_last, output frame_last,
                  input ready);
  modport sink   (input valid, input avg_pixel, input row_last, input frame_last,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/bbd_cfg_if.sv
// ---------------------------------------------------------------------------
// bbd_cfg_if: configuration write channel
// valid/ready handshake carrying a register index and write data.
// ---------------------------------------------------------------------------
`default_nettype none

interface bbd_cfg_if;
  import bbd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/bbd_ram.sv
// ---------------------------------------------------------------------------
// bbd_ram: simple dual port RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module bbd_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 25
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/bbd_front.sv
// ---------------------------------------------------------------------------
// bbd_front: configuration, raster counters and horizontal accumulation
// Sums pixels across a block row, issues the line store read when a block
// row closes and hands the segment to the update stage.
// ---------------------------------------------------------------------------
`default_nettype none

module bbd_front (
  input  logic                     clk,
  input  logic                     rst,
  bbd_pix_if.sink                  pix_in,
  bbd_cfg_if.sink                  cfg,
  input  logic                     s1_adv,
  output logic                     s1_valid,
  output bbd_pkg::bbd_item_t       s1_item,
  output logic                     rd_en,
  output logic [bbd_pkg::COL_W-1:0] rd_addr
);
  import bbd_pkg::*;

  logic [SHIFT_W-1:0]      shift_amount;
  logic [WIDTH_W-1:0]      image_width;
  logic [HEIGHT_W-1:0]     image_height;
  logic                    signed_pixels;

  logic [COL_W-1:0]        column_count;
  logic [ROW_W-1:0]        row_count;
  logic signed [BRS_W-1:0] block_row_sum;

  logic [SH_W-1:0]         eff_shift;
  logic [WIDTH_W-1:0]      eff_width;
  logic [HEIGHT_W-1:0]     eff_height;
  logic [MAX_SHIFT-1:0]    edge_mask;
  logic [WIDTH_W-1:0]      col_inc;
  logic [ROW_W:0]          row_inc;
  logic                    row_end;
  logic                    frame_end;
  logic                    col_close;
  logic                    band_first;
  logic                    band_close;
  logic signed [BRS_W-1:0] pix_val;
  logic signed [BRS_W-1:0] sum_base;
  logic signed [BRS_W-1:0] sum_next;
  logic                    accept;

  assign eff_shift  = (shift_amount > SHIFT_W'(MAX_SHIFT)) ? SH_W'(MAX_SHIFT)
                                                           : SH_W'(shift_amount);
  assign eff_width  = (image_width == '0) ? WIDTH_W'(1) :
                      (image_width > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH)
                                                          : image_width;
  assign eff_height = (image_height == '0) ? HEIGHT_W'(1) : image_height;
  assign edge_mask  = MAX_SHIFT'((1 << eff_shift) - 1);

  assign col_inc    = WIDTH_W'(column_count) + WIDTH_W'(1);
  assign row_inc    = {1'b0, row_count} + (ROW_W+1)'(1);
  assign row_end    = (col_inc >= eff_width);
  assign frame_end  = row_end && (row_inc >= {1'b0, eff_height});
  assign col_close  = ((column_count[MAX_SHIFT-1:0] & edge_mask) == edge_mask) || row_end;
  assign band_first = (row_count[MAX_SHIFT-1:0] & edge_mask) == '0;
  assign band_close = ((row_count[MAX_SHIFT-1:0] & edge_mask) == edge_mask) ||
                      (row_inc >= {1'b0, eff_height});

  assign pix_val  = signed_pixels ? BRS_W'($signed(pix_in.pixel))
                                  : BRS_W'($signed({1'b0, pix_in.pixel}));
  assign sum_base = ((column_count[MAX_SHIFT-1:0] & edge_mask) == '0) ? '0 : block_row_sum;
  assign sum_next = sum_base + pix_val;

  assign accept       = pix_in.valid && pix_in.ready;
  assign pix_in.ready = !s1_valid || s1_adv;
  assign cfg.ready    = 1'b1;

  assign rd_en   = accept && col_close;
  assign rd_addr = column_count >> eff_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_amount  <= '0;
      image_width   <= WIDTH_W'(4096);
      image_height  <= HEIGHT_W'(4096);
      signed_pixels <= 1'b0;
      column_count  <= '0;
      row_count     <= '0;
      block_row_sum <= '0;
      s1_valid      <= 1'b0;
    end else if (cfg.valid) begin
      // any register write restarts the frame
      unique case (cfg_reg_t'(cfg.index))
        REG_SHIFT:  shift_amount  <= cfg.data[SHIFT_W-1:0];
        REG_WIDTH:  image_width   <= cfg.data[WIDTH_W-1:0];
        REG_HEIGHT: image_height  <= cfg.data[HEIGHT_W-1:0];
        REG_SIGNED: signed_pixels <= cfg.data[0];
        default:    signed_pixels <= signed_pixels;
      endcase
      column_count  <= '0;
      row_count     <= '0;
      block_row_sum <= '0;
      s1_valid      <= s1_valid && !s1_adv;
    end else begin
      if (accept) begin
        block_row_sum <= col_close ? '0 : sum_next;
        if (row_end) begin
          column_count <= '0;
          row_count    <= frame_end ? '0 : row_inc[ROW_W-1:0];
        end else begin
          column_count <= col_inc[COL_W-1:0];
        end
      end
      if (accept && col_close) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && col_close) begin
      s1_item.sum        <= sum_next;
      s1_item.bc         <= rd_addr;
      s1_item.shift      <= eff_shift;
      s1_item.band_first <= band_first;
      s1_item.band_close <= band_close;
      s1_item.row_end    <= row_end;
      s1_item.frame_end  <= frame_end;
    end
  end

endmodule

`default_nettype wire

>>> hdl/bbd_back.sv
// ---------------------------------------------------------------------------
// bbd_back: line store update and averaging
// Adds the segment to its column sum (with write forwarding), writes the
// sum back and, on the last row of a band, divides and registers the result.
// ---------------------------------------------------------------------------
`default_nettype none

module bbd_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s1_valid,
  input  bbd_pkg::bbd_item_t         s1_item,
  input  logic [bbd_pkg::CSUM_W-1:0] rd_data,
  output logic                       s1_adv,
  output logic                       wr_en,
  output logic [bbd_pkg::COL_W-1:0]  wr_addr,
  output logic [bbd_pkg::CSUM_W-1:0] wr_data,
  bbd_out_if.source                  avg_out
);
  import bbd_pkg::*;

  logic                     lw_valid;
  logic [COL_W-1:0]         lw_addr;
  logic [CSUM_W-1:0]        lw_data;
  logic                     out_valid;

  logic signed [CSUM_W-1:0] prior;
  logic signed [CSUM_W-1:0] seg;
  logic signed [CSUM_W-1:0] total;
  logic [SH_W:0]            div_sh;
  logic signed [CSUM_W-1:0] bias;
  logic signed [CSUM_W-1:0] biased;
  logic signed [CSUM_W-1:0] avg;
  logic                     emit;

  // the read may have raced the previous write to the same column
  assign prior  = (lw_valid && (lw_addr == s1_item.bc)) ? $signed(lw_data) : $signed(rd_data);
  assign seg    = {{(CSUM_W-BRS_W){s1_item.sum[BRS_W-1]}}, s1_item.sum};
  assign total  = s1_item.band_first ? seg : prior + seg;

  // divide by 4^shift, truncating toward zero
  assign div_sh = {s1_item.shift, 1'b0};
  assign bias   = CSUM_W'((1 << div_sh) - 1);
  assign biased = total + (total[CSUM_W-1] ? bias : '0);
  assign avg    = biased >>> div_sh;

  assign emit    = s1_item.band_close;
  assign s1_adv  = s1_valid && (!emit || !out_valid || avg_out.ready);
  assign wr_en   = s1_adv;
  assign wr_addr = s1_item.bc;
  assign wr_data = total;

  assign avg_out.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        lw_valid <= 1'b1;
      end
      if (s1_adv && emit) begin
        out_valid <= 1'b1;
      end else if (avg_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      lw_addr <= s1_item.bc;
      lw_data <= total;
    end
    if (s1_adv && emit) begin
      avg_out.avg_pixel  <= avg[OUT_W-1:0];
      avg_out.row_last   <= s1_item.row_end;
      avg_out.frame_last <= s1_item.frame_end;
    end
  end

endmodule

`default_nettype wire

>>> hdl/image_box_binning_downscaler.sv
// A result reaches avg_out through the segment register and then the output register.
// Throughput: one pixel per cycle; each closed block row does one read-modify-write of its
//   column sum in the line store, with the last write forwarded to a racing read.
// A full output register stalls pixels only when the next result is due while ready is low.
// Reset (rst, synchronous): counters cleared, registers to shift 0, 4096 x 4096, unsigned.
// The line store is not cleared: every entry is written on a band's first row before use.
// ---------------------------------------------------------------------------
// image_box_binning_downscaler: 2^s x 2^s box average of a raster pixel stream
// Pixels are summed along each block row, then accumulated per block column
// in a line store; the last row of a band produces the block average.
// ---------------------------------------------------------------------------
`default_nettype none

module image_box_binning_downscaler (
  input  logic      clk,
  input  logic      rst,
  bbd_pix_if.sink   pix_in,
  bbd_out_if.source avg_out,
  bbd_cfg_if.sink   cfg
);
  import bbd_pkg::*;

  // segment word between the accumulate stage and the update stage
  logic              s1_valid;
  logic              s1_adv;
  bbd_item_t         s1_item;

  // line store ports
  logic              rd_en;
  logic [COL_W-1:0]  rd_addr;
  logic [CSUM_W-1:0] rd_data;
  logic              wr_en;
  logic [COL_W-1:0]  wr_addr;
  logic [CSUM_W-1:0] wr_data;

  // counters, config registers and per-row accumulation; issues the read
  bbd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .pix_in   (pix_in),
    .cfg      (cfg),
    .s1_adv   (s1_adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr)
  );

  // per block column partial sums of the current band
  bbd_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (CSUM_W)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // modify and write back, divide, output register
  bbd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .rd_data  (rd_data),
    .s1_adv   (s1_adv),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .avg_out  (avg_out)
  );

endmodule

`default_nettype wire
